### rtl/base64url_stream_encoder_assert.svh
// assertion macros shared by the base64url encoder modules
`ifndef BASE64URL_STREAM_ENCODER_ASSERT_SVH
`define BASE64URL_STREAM_ENCODER_ASSERT_SVH

// condition implies consequence in the same cycle
`define B64U_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define B64U_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### rtl/b64u_pkg.sv
// shared types, constants and the character table of the base64url encoder
package b64u_pkg;

  // default depth of the job queue between front and back
  localparam int unsigned B64U_QUEUE_DEPTH = 2;

  // one encoding job: one or two six-bit codes for a single input byte
  typedef struct packed {
    logic [5:0] first;
    logic [5:0] second;
    logic       two;
    logic       last;
  } b64u_job_t;

  // url-safe alphabet lookup: six-bit code to ascii
  function automatic logic [7:0] b64u_char(input logic [5:0] six);
    logic [7:0] code;
    code = {2'b00, six};
    if (six < 6'd26) begin
      b64u_char = code + 8'd65;
    end else if (six < 6'd52) begin
      b64u_char = code + 8'd71;
    end else if (six < 6'd62) begin
      b64u_char = code - 8'd4;
    end else if (six == 6'd62) begin
      b64u_char = 8'd45;
    end else begin
      b64u_char = 8'd95;
    end
  endfunction

endpackage

### rtl/b64u_front.sv
// front end: accepts bytes, tracks group position and leftover bits, forms jobs
module b64u_front
  import b64u_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output b64u_job_t  job
);

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;

  logic [1:0] group_position;
  logic [1:0] group_position_next;
  logic [3:0] leftover_bits;
  logic [3:0] leftover_bits_next;

  // split the byte into codes by its place in the group
  always_comb begin
    job.last = end_of_message;
    case (group_position)
      POS_SECOND: begin
        job.first           = {leftover_bits[1:0], data_byte[7:4]};
        job.second          = {data_byte[3:0], 2'b00};
        job.two             = end_of_message;
        group_position_next = POS_THIRD;
        leftover_bits_next  = data_byte[3:0];
      end
      POS_THIRD: begin
        job.first           = {leftover_bits, data_byte[7:6]};
        job.second          = data_byte[5:0];
        job.two             = 1'b1;
        group_position_next = POS_FIRST;
        leftover_bits_next  = 4'd0;
      end
      default: begin
        // start of group, and the unused position wraps to here
        job.first           = data_byte[7:2];
        job.second          = {data_byte[1:0], 4'b0000};
        job.two             = end_of_message;
        group_position_next = POS_SECOND;
        leftover_bits_next  = {2'b00, data_byte[1:0]};
      end
    endcase
    // a message end restarts the group
    if (end_of_message) begin
      group_position_next = POS_FIRST;
      leftover_bits_next  = 4'd0;
    end
  end

  // group state update on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= POS_FIRST;
      leftover_bits  <= 4'd0;
    end else if (accept) begin
      group_position <= group_position_next;
      leftover_bits  <= leftover_bits_next;
    end
  end

endmodule

### rtl/b64u_fifo.sv
// small register queue carrying jobs from front to back
`include "base64url_stream_encoder_assert.svh"
module b64u_fifo
  import b64u_pkg::*;
#(
  parameter int unsigned WIDTH = $bits(b64u_job_t),
  parameter int unsigned DEPTH = B64U_QUEUE_DEPTH
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  // status and qualified strobes
  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  `B64U_ASSERT_NOW(a_count_bound, 1'b1, count <= FULL_CNT, "queue count beyond depth")
  `B64U_ASSERT_NEXT(a_count_push, do_wr && !do_rd, count == $past(count) + 1'b1, "lost push")
  `B64U_ASSERT_NEXT(a_count_pop, do_rd && !do_wr, count == $past(count) - 1'b1, "lost pop")

endmodule

### rtl/b64u_back.sv
// back end: turns jobs into characters, one per cycle while the receiver pops, through an output register
`include "base64url_stream_encoder_assert.svh"
module b64u_back
  import b64u_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       job_empty,
  input  b64u_job_t  job,
  output logic       job_pop,
  output logic [7:0] out_char,
  output logic       last_char,
  output logic       empty,
  input  logic       pop
);

  logic       out_valid;
  logic       pending;
  logic [5:0] second_six;
  logic       second_last;
  logic       slot_free;

  // output slot frees when empty or being taken
  assign slot_free = !out_valid || pop;
  assign job_pop   = slot_free && !pending && !job_empty;
  assign empty     = !out_valid;

  // control: output valid and waiting second character
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pending   <= 1'b0;
    end else if (slot_free) begin
      if (pending) begin
        out_valid <= 1'b1;
        pending   <= 1'b0;
      end else if (!job_empty) begin
        out_valid <= 1'b1;
        pending   <= job.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: character and last mark
  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pending) begin
        out_char  <= b64u_char(second_six);
        last_char <= second_last;
      end else if (!job_empty) begin
        out_char    <= b64u_char(job.first);
        last_char   <= job.last && !job.two;
        second_six  <= job.second;
        second_last <= job.last;
      end
    end
  end

  `B64U_ASSERT_NOW(a_pending_shown, pending, out_valid, "second character waits with no output")
  `B64U_ASSERT_NOW(a_pop_slot, job_pop, slot_free && !pending, "job taken while output busy")
  `B64U_ASSERT_NEXT(a_two_pending, job_pop && job.two, pending && out_valid, "second character lost")

endmodule

### rtl/base64url_stream_encoder.sv
// Base64url encoder without padding: one raw byte per pushed item, end_of_message on the last
// byte; characters (A-Z a-z 0-9 - _) come out one per popped item, last_char on the final one.
// A byte is accepted in any cycle while the job queue (two entries by default) has room; its
// job passes through the queue and then the output register. The output register delivers one
// character per cycle while it is popped, so a byte that yields two characters (third of a
// group, or the last byte) holds it for both, and no new job is taken until the second is out.
module base64url_stream_encoder
  import b64u_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = B64U_QUEUE_DEPTH
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       last_char
);

  localparam int unsigned JOB_W = $bits(b64u_job_t);

  b64u_job_t        front_job;
  b64u_job_t        back_job;
  logic [JOB_W-1:0] queue_rd_data;
  logic             queue_empty;
  logic             queue_pop;
  logic             accept;

  // input item handshake
  assign accept   = push && !full;
  assign back_job = b64u_job_t'(queue_rd_data);

  // front: classify bytes
  b64u_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .job            (front_job)
  );

  // queue between front and back
  b64u_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (JOB_W'(front_job)),
    .rd_en   (queue_pop),
    .rd_data (queue_rd_data),
    .full    (full),
    .empty   (queue_empty)
  );

  // back: emit characters
  b64u_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (queue_empty),
    .job       (back_job),
    .job_pop   (queue_pop),
    .out_char  (out_char),
    .last_char (last_char),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

### verif/tb_base64url_stream_encoder.sv
// self-checking testbench for the base64url stream encoder: predicts each character and compares
module tb_base64url_stream_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  // url-safe alphabet, first character in the top byte
  localparam logic [8*64-1:0] URL_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } enc_char_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_message = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_char;
  logic       last_char;

  // predictor state and the characters still due from the block
  logic [1:0] group_pos = 2'd0;
  logic [3:0] held_bits = 4'd0;
  enc_char_t  chars_due[$];

  int fail_count = 0;
  int send_idle_pct = 0;
  int pop_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  base64url_stream_encoder DUT (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .empty          (empty),
    .pop            (pop),
    .out_char       (out_char),
    .last_char      (last_char)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  // queue one expected character from its six-bit code
  task automatic add_char(input logic [5:0] six, input logic is_last);
    enc_char_t c;
    c.code = URL_ALPHABET[8*(63 - six) +: 8];
    c.last = is_last;
    chars_due.push_back(c);
  endtask

  // advance the encoding state by one accepted byte
  task automatic encode_byte(input logic [7:0] b, input logic eom);
    case (group_pos)
      2'd1: begin
        add_char({held_bits[1:0], b[7:4]}, 1'b0);
        held_bits = b[3:0];
        group_pos = 2'd2;
        if (eom) begin
          add_char({b[3:0], 2'b00}, 1'b1);
        end
      end
      2'd2: begin
        add_char({held_bits, b[7:6]}, 1'b0);
        add_char(b[5:0], eom);
        held_bits = 4'd0;
        group_pos = 2'd0;
      end
      default: begin
        add_char(b[7:2], 1'b0);
        held_bits = {2'b00, b[1:0]};
        group_pos = 2'd1;
        if (eom) begin
          add_char({b[1:0], 4'b0000}, 1'b1);
        end
      end
    endcase
    if (eom) begin
      group_pos = 2'd0;
      held_bits = 4'd0;
    end
  endtask

  // offer one item and hold it until the block takes it, then maybe pause
  task automatic send_byte(input logic [7:0] b, input logic eom);
    push           <= 1'b1;
    data_byte      <= b;
    end_of_message <= eom;
    do @(posedge clk); while (full);
    encode_byte(b, eom);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // one message of random bytes, flagged on its last byte
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom), i == len - 1);
    end
  endtask

  // receiver: random pop, optional long hold-off, checks every popped item
  initial begin
    enc_char_t want;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (chars_due.size() == 0) begin
          $error("out_char: no character expected, got %h", out_char);
          fail_count++;
        end else begin
          want = chars_due.pop_front();
          if (out_char !== want.code) begin
            $error("out_char: expected %h, got %h", want.code, out_char);
            fail_count++;
          end
          if (last_char !== want.last) begin
            $error("last_char: expected %b, got %b", want.last, last_char);
            fail_count++;
          end
        end
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= pop_idle_pct);
      end
    end
  end

  // extremes and every final-byte position in a group
  task automatic test_directed();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // dash and underscore runs
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'hFF, 1'b1);
    // a message ending in the second place of its second group
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  // random messages, mostly short, a few long
  task automatic test_random(input int n_bytes, input int send_pct, input int pop_pct);
    int sent;
    int len;
    int sel;
    send_idle_pct = send_pct;
    pop_idle_pct  = pop_pct;
    sent = 0;
    while (sent < n_bytes) begin
      sel = $urandom_range(99);
      if (sel < 85) begin
        len = $urandom_range(1, 6);
      end else if (sel < 97) begin
        len = $urandom_range(7, 24);
      end else begin
        len = $urandom_range(25, 64);
      end
      if (len > n_bytes - sent) begin
        len = n_bytes - sent;
      end
      send_message(len);
      sent += len;
    end
  endtask

  // receiver stalls for a long stretch while items keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    pop_idle_pct  = 0;
    hold_request  = 200;
    send_message(30);
    send_message(12);
  endtask

  // stop offering and wait for every due character
  task automatic drain();
    push <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // main sequence
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(600, 9, 73);
    test_backpressure();
    test_random(600, 73, 9);
    test_random(600, 0, 0);
    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### base64url_stream_encoder.f
+incdir+rtl
rtl/b64u_pkg.sv
rtl/b64u_front.sv
rtl/b64u_fifo.sv
rtl/b64u_back.sv
rtl/base64url_stream_encoder.sv
verif/tb_base64url_stream_encoder.sv
